FILE: src/ppqc_pkg.sv
// Shared types, widths and helpers for the polygon perimeter block.
// Depends on nothing; every other file of the block imports it.
package ppqc_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int SUM_WIDTH       = 25;
   localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
   localparam int ROOT_WIDTH      = COORD_WIDTH + 1;
   localparam int RAD_WIDTH       = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH       = ROOT_WIDTH + 3;
   localparam int STEP_WIDTH      = $clog2(ROOT_WIDTH);
   localparam int DEF_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] perimeter;
      logic                 only_first_third;
   } rsp_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] edge_x;
      logic [COORD_WIDTH-1:0] edge_y;
      logic                   edge_on;
      logic [COORD_WIDTH-1:0] close_x;
      logic [COORD_WIDTH-1:0] close_y;
      logic                   close_on;
      logic                   quad_ok;
   } edge_job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQ_X,
      BK_SQ_Y,
      BK_ADD,
      BK_ROOT,
      BK_ACCUM,
      BK_EMIT
   } back_state_type;

   function automatic logic [COORD_WIDTH-1:0] abs_diff(
      input logic [COORD_WIDTH-1:0] a,
      input logic [COORD_WIDTH-1:0] b
   );
      logic [COORD_WIDTH:0] d;
      logic [COORD_WIDTH:0] m;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      m = d[COORD_WIDTH] ? (~d + 1'b1) : d;
      return m[COORD_WIDTH-1:0];
   endfunction

endpackage

FILE: src/ppqc_front.sv
// Front end: takes vertices, tracks first and previous vertex and the quadrant flag,
// and turns each vertex but a first non-last one into an edge job. Depends on ppqc_pkg.
module ppqc_front import ppqc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         job_valid,
   input  logic         job_ready,
   output edge_job_type job_data
);

   logic [COORD_WIDTH-1:0] start_x_ff, start_y_ff, prior_x_ff, prior_y_ff;
   logic                   have_start_ff, have_start_in;
   logic                   quad_ok_ff, quad_ok_in;
   logic                   fire, x_pos, x_neg, y_pos, y_neg, quad_here;
   logic [COORD_WIDTH-1:0] cur_x, cur_y, ref_x, ref_y;

   assign cur_x     = req_data.x_coord;
   assign cur_y     = req_data.y_coord;
   assign req_ready = job_ready;
   assign fire      = req_valid && job_ready;

   assign x_neg     = cur_x[COORD_WIDTH-1];
   assign y_neg     = cur_y[COORD_WIDTH-1];
   assign x_pos     = !x_neg && (|cur_x);
   assign y_pos     = !y_neg && (|cur_y);
   assign quad_here = !((x_pos && y_neg) || (x_neg && y_pos));

   // closing edge of a lone vertex goes back to itself
   assign ref_x = have_start_ff ? start_x_ff : cur_x;
   assign ref_y = have_start_ff ? start_y_ff : cur_y;

   always_comb begin
      job_data.edge_x   = abs_diff(prior_x_ff, cur_x);
      job_data.edge_y   = abs_diff(prior_y_ff, cur_y);
      job_data.edge_on  = have_start_ff;
      job_data.close_x  = abs_diff(cur_x, ref_x);
      job_data.close_y  = abs_diff(cur_y, ref_y);
      job_data.close_on = req_data.last_vertex;
      job_data.quad_ok  = quad_ok_ff && quad_here;
   end

   assign job_valid = fire && (have_start_ff || req_data.last_vertex);

   always_comb begin
      have_start_in = have_start_ff;
      quad_ok_in    = quad_ok_ff;
      if (fire) begin
         if (req_data.last_vertex) begin
            have_start_in = 1'b0;
            quad_ok_in    = 1'b1;
         end else begin
            have_start_in = 1'b1;
            quad_ok_in    = quad_ok_ff && quad_here;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_start_ff <= 1'b0;
         quad_ok_ff    <= 1'b1;
      end else begin
         have_start_ff <= have_start_in;
         quad_ok_ff    <= quad_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prior_x_ff <= cur_x;
         prior_y_ff <= cur_y;
         if (!have_start_ff) begin
            start_x_ff <= cur_x;
            start_y_ff <= cur_y;
         end
      end
   end

endmodule

FILE: src/ppqc_queue.sv
// Short queue of edge jobs between front and back end.
// Depends on ppqc_pkg for the job type.
module ppqc_queue import ppqc_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  edge_job_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output edge_job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   edge_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/ppqc_back.sv
// Back end: squares each edge, takes its integer root two bits a step, keeps the
// saturating sum and holds the result register. Depends on ppqc_pkg.
module ppqc_back import ppqc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_ready,
   input  edge_job_type job_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   back_state_type         state_ff, state_in;
   edge_job_type           job_ff, job_in;
   logic                   closing_ff, closing_in;
   logic [SQ_WIDTH-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_WIDTH-1:0]   rad_ff, rad_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_WIDTH-1:0]  root_ff, root_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [SUM_WIDTH:0]     total;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [COORD_WIDTH-1:0] op_x, op_y;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign job_ready = (state_ff == BK_IDLE);

   assign op_x   = closing_ff ? job_ff.close_x : job_ff.edge_x;
   assign op_y   = closing_ff ? job_ff.close_y : job_ff.edge_y;
   assign rem_sh = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial  = REM_WIDTH'({root_ff, 2'b01});
   assign total  = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(root_ff);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      closing_in   = closing_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_in     = job_data;
               closing_in = !job_data.edge_on;
               state_in   = BK_SQ_X;
            end
         end
         BK_SQ_X: begin
            sqx_in   = SQ_WIDTH'(op_x) * SQ_WIDTH'(op_x);
            state_in = BK_SQ_Y;
         end
         BK_SQ_Y: begin
            sqy_in   = SQ_WIDTH'(op_y) * SQ_WIDTH'(op_y);
            state_in = BK_ADD;
         end
         BK_ADD: begin
            rad_in   = RAD_WIDTH'(sqx_ff) + RAD_WIDTH'(sqy_ff);
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = BK_ROOT;
         end
         BK_ROOT: begin
            rad_in = {rad_ff[RAD_WIDTH-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(ROOT_WIDTH - 1)) begin
               state_in = BK_ACCUM;
            end
         end
         BK_ACCUM: begin
            sum_in = total[SUM_WIDTH] ? '1 : total[SUM_WIDTH-1:0];
            if (job_ff.close_on && !closing_ff) begin
               closing_in = 1'b1;
               state_in   = BK_SQ_X;
            end else if (job_ff.close_on) begin
               state_in = BK_EMIT;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.perimeter        = sum_ff;
               rsp_data_in.only_first_third = job_ff.quad_ok;
               rsp_valid_in                 = 1'b1;
               sum_in                       = '0;
               state_in                     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         closing_ff   <= 1'b0;
         step_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         closing_ff   <= closing_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: src/polygon_perimeter_quadrant_check_top.sv
// Polygon perimeter with first/third-quadrant check. Vertices arrive one per request as
// signed Q8.8 pairs; the request flagged last closes the polygon and yields one response
// with the saturating Q.8 perimeter and the quadrant flag. Each edge goes through the
// back end's shared root unit (squaring x, squaring y, adding, seventeen root steps,
// one accumulate), so an ordinary vertex costs one edge, a last vertex also the closing
// edge and a step to load the response. A first vertex that is not last uses no root.
// The front end accepts requests while its queue has room, so it runs ahead of the
// root unit by up to QUEUE_DEPTH edge jobs.
// Depends on ppqc_pkg, ppqc_front, ppqc_queue and ppqc_back.
module polygon_perimeter_quadrant_check_top import ppqc_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         push_valid, push_ready, pop_valid, pop_ready;
   edge_job_type push_data, pop_data;

   ppqc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   ppqc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ppqc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for polygon_perimeter_quadrant_check_top: random-gap request driver,
// response monitor and a vertex-level perimeter and quadrant predictor.
// Depends on ppqc_pkg and the block's RTL only.
module tb_top import ppqc_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                   STALL_LIMIT = 6000;
   localparam int                   HOLD_CYCLES = 400;
   localparam logic [SUM_WIDTH-1:0] SUM_CEIL    = {SUM_WIDTH{1'b1}};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type vertex_queue[$];
   rsp_type expected_perims[$];

   logic signed [COORD_WIDTH-1:0] first_x, first_y, last_x, last_y;
   logic [SUM_WIDTH-1:0]          perim_acc;
   logic                          quad_flag;
   logic                          first_held;

   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   int   req_gap        = 0;
   int   rsp_gap        = 0;
   int   hold_left      = 0;
   int   rsp_seen       = 0;
   logic req_taken      = 1'b0;
   logic rsp_taken      = 1'b0;

   polygon_perimeter_quadrant_check_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [ROOT_WIDTH:0] isqrt_floor(input longint unsigned n);
      logic [ROOT_WIDTH:0] root;
      longint unsigned     trial;
      root = '0;
      for (int b = ROOT_WIDTH; b >= 0; b--) begin
         trial = longint'(root) | (64'd1 << b);
         if (trial * trial <= n) root = trial[ROOT_WIDTH:0];
      end
      return root;
   endfunction

   function automatic logic [ROOT_WIDTH:0] edge_length(
      input logic signed [COORD_WIDTH-1:0] ax,
      input logic signed [COORD_WIDTH-1:0] ay,
      input logic signed [COORD_WIDTH-1:0] bx,
      input logic signed [COORD_WIDTH-1:0] by
   );
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return isqrt_floor(longint'(dx * dx + dy * dy));
   endfunction

   function automatic logic [SUM_WIDTH-1:0] sat_add(
      input logic [SUM_WIDTH-1:0] acc,
      input logic [ROOT_WIDTH:0]  len
   );
      logic [SUM_WIDTH:0] total;
      total = {1'b0, acc} + len;
      return (total > {1'b0, SUM_CEIL}) ? SUM_CEIL : total[SUM_WIDTH-1:0];
   endfunction

   task automatic clear_polygon();
      first_x    = '0;
      first_y    = '0;
      last_x     = '0;
      last_y     = '0;
      perim_acc  = '0;
      quad_flag  = 1'b1;
      first_held = 1'b0;
   endtask

   task automatic trace_vertex(input req_type v);
      rsp_type res;
      if ((v.x_coord > 0 && v.y_coord < 0) || (v.x_coord < 0 && v.y_coord > 0))
         quad_flag = 1'b0;
      if (!first_held) begin
         first_x    = v.x_coord;
         first_y    = v.y_coord;
         first_held = 1'b1;
      end else begin
         perim_acc = sat_add(perim_acc, edge_length(last_x, last_y, v.x_coord, v.y_coord));
      end
      last_x = v.x_coord;
      last_y = v.y_coord;
      if (v.last_vertex) begin
         perim_acc            = sat_add(perim_acc,
                                        edge_length(v.x_coord, v.y_coord, first_x, first_y));
         res.perimeter        = perim_acc;
         res.only_first_third = quad_flag;
         expected_perims.push_back(res);
         clear_polygon();
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] any_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
         1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
         2: return '0;
         3, 4, 5: return COORD_WIDTH'($signed($urandom_range(0, 1023)) - 512);
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   task automatic push_vertex(
      input logic signed [COORD_WIDTH-1:0] x,
      input logic signed [COORD_WIDTH-1:0] y,
      input logic                          last
   );
      req_type v;
      v.x_coord     = x;
      v.y_coord     = y;
      v.last_vertex = last;
      vertex_queue.push_back(v);
   endtask

   task automatic build_stimulus();
      int                            items;
      int                            polys;
      int                            len;
      int                            r;
      logic                          tame;
      logic signed [COORD_WIDTH-1:0] x, y;
      logic signed [COORD_WIDTH-1:0] neg_max, pos_max;
      neg_max = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      pos_max = {1'b0, {(COORD_WIDTH-1){1'b1}}};

      push_vertex('0, '0, 1'b1);
      push_vertex(neg_max, neg_max, 1'b1);
      push_vertex(pos_max, neg_max, 1'b1);
      push_vertex(neg_max, pos_max, 1'b1);
      push_vertex(neg_max, neg_max, 1'b0);
      push_vertex(pos_max, pos_max, 1'b1);
      push_vertex('0, neg_max, 1'b0);
      push_vertex(neg_max, '0, 1'b1);
      push_vertex('0, '0, 1'b0);
      push_vertex(16'sh0300, '0, 1'b0);
      push_vertex('0, 16'sh0400, 1'b1);
      push_vertex(16'sh0100, 16'sh0100, 1'b0);
      push_vertex(-16'sh0100, 16'sh0100, 1'b0);
      push_vertex(-16'sh0100, -16'sh0100, 1'b0);
      push_vertex(16'sh0100, -16'sh0100, 1'b1);

      // long zig-zag between far corners to drive the sum into saturation
      for (int i = 0; i < 400; i++) begin
         if (i % 2 == 0)
            push_vertex(neg_max + COORD_WIDTH'($urandom_range(0, 3)),
                        neg_max + COORD_WIDTH'($urandom_range(0, 3)), 1'b0);
         else
            push_vertex(pos_max - COORD_WIDTH'($urandom_range(0, 3)),
                        pos_max - COORD_WIDTH'($urandom_range(0, 3)), i == 399);
      end

      items = 0;
      polys = 0;
      while (items < 100 || polys < 20) begin
         r = $urandom_range(0, 9);
         if (r < 6) len = $urandom_range(1, 4);
         else if (r < 9) len = $urandom_range(5, 10);
         else len = $urandom_range(11, 24);
         tame = $urandom_range(0, 1);
         for (int k = 0; k < len; k++) begin
            x = any_coord();
            y = any_coord();
            if (tame && ((x > 0 && y < 0) || (x < 0 && y > 0))) y = ~y;
            push_vertex(x, y, k == len - 1);
         end
         items += len;
         polys++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         clear_polygon();
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_perims.size() == 0) begin
               $display("%0t unexpected response perimeter=%0d flag=%0b",
                        $time, rsp_data.perimeter, rsp_data.only_first_third);
               mismatch_count++;
            end else begin
               rsp_type want;
               want = expected_perims.pop_front();
               if (rsp_data.perimeter !== want.perimeter) begin
                  $display("%0t perimeter expected %0d actual %0d",
                           $time, want.perimeter, rsp_data.perimeter);
                  mismatch_count++;
               end
               if (rsp_data.only_first_third !== want.only_first_third) begin
                  $display("%0t only_first_third expected %0b actual %0b",
                           $time, want.only_first_third, rsp_data.only_first_third);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) trace_vertex(req_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : drive_requests
      logic    nv;
      req_type nd;
      nv = req_valid;
      nd = req_data;
      if (!reset) begin
         if (req_valid && req_taken) nv = 1'b0;
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (vertex_queue.size() > 0) begin
               nd      = vertex_queue.pop_front();
               nv      = 1'b1;
               req_gap = pick_gap();
            end
         end
      end
      req_valid <= nv;
      req_data  <= nd;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_seen++;
            // hold off for a long stretch so the block fills and stalls requests
            if (rsp_seen == 20 || rsp_seen == 25) hold_left = HOLD_CYCLES;
            else rsp_gap = pick_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      build_stimulus();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (vertex_queue.size() == 0 && req_valid == 1'b0);
      wait (expected_perims.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_perims.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/ppqc_pkg.sv
src/ppqc_front.sv
src/ppqc_queue.sv
src/ppqc_back.sv
src/polygon_perimeter_quadrant_check_top.sv
dv/tb_top.sv
